[rtl/core/tfs_pkg.sv]
// Shared types and constants for the telemetry frame synchronizer.
// Depends on nothing; imported by the core, by its checker and by the testbench.
package tfs_pkg;

   localparam int BYTE_W        = 8;
   localparam int SYNC_W        = 16;
   localparam int LEN_W         = 7;
   localparam int IDX_W         = 6;
   localparam int CTR_W         = 16;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 16;

   localparam int MAX_FRAME_DEF = 64;
   localparam int MIN_FRAME     = 4;
   localparam int LEN_RESET     = 64;
   localparam int SYNC_BYTES    = 2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SYNC_WORD    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_LENGTH = CSR_IDX_W'(1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CTR_LO,
      ST_CTR_HI,
      ST_CTR_DONE,
      ST_EMIT
   } tfs_state_type;

endpackage

[rtl/core/telemetry_frame_synchronizer.sv]
// Telemetry frame synchronizer: sync-word framing of a received byte stream.
// Depends on tfs_pkg. One module; the frame bytes live in a circular store.
//
// Usage
//   req_* carries one received byte per beat (req_valid / req_stall).
//   rsp_* carries one byte of a confirmed frame per beat, with its index,
//   the frame counter (frame bytes 0 and 1, little endian) and a last flag.
//   csr_* writes sync_word (index 0) or frame_length (index 1); either write
//   restarts the hunt. Writes are taken only while the sequencer is idle.
// Timing
//   A byte that neither ends a frame nor starts a relock leaves the
//   sequencer idle. A byte that ends a frame starts a readout: CTR_LO,
//   CTR_HI and CTR_DONE fetch the frame counter from the store, then EMIT
//   makes one store read per byte; no byte is taken until the readout ends.
//   Beats go out one per cycle while rsp_stall is low; the single read port
//   sets this rate. A relock after a failed frame scans the kept bytes for
//   the next sync pair, one store read per cycle with the read stage empty.
// Reset
//   Synchronous, active high: hunting, nothing held, sync_word 0,
//   frame_length 64. Store contents stay undefined until written.
// Stall
//   rsp_stall holds the output register; a one-deep read stage behind it
//   keeps one more byte, then the readout pauses until the stall clears.
module telemetry_frame_synchronizer #(
   parameter int MAX_FRAME = tfs_pkg::MAX_FRAME_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // received bytes
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [tfs_pkg::BYTE_W-1:0]      req_rx_byte,
   // frame bytes
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [tfs_pkg::BYTE_W-1:0]      rsp_out_byte,
   output logic [tfs_pkg::IDX_W-1:0]       rsp_byte_index,
   output logic [tfs_pkg::CTR_W-1:0]       rsp_frame_counter,
   output logic                            rsp_last_of_frame,
   // register writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [tfs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tfs_pkg::CSR_DATA_W-1:0]  csr_data
);
   import tfs_pkg::*;

   localparam int AW    = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
   localparam int DEPTH = 1 << AW;

   // frame store and its registered read port
   logic [BYTE_W-1:0] frame_store_ff [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;

   tfs_state_type state_ff, state_in;

   logic [SYNC_W-1:0] sync_ff, sync_in;
   logic [LEN_W-1:0]  flen_ff, flen_in;
   logic              lock_ff, lock_in;
   logic [LEN_W-1:0]  held_ff, held_in;
   logic [BYTE_W-1:0] prev_ff, prev_in;
   logic [LEN_W-1:0]  off_ff, off_in;
   logic              seen_ff, seen_in;
   logic [AW-1:0]     base_ff, base_in;

   // relock scan
   logic [LEN_W-1:0]  scan_idx_ff, scan_idx_in;
   logic              pend_ff, pend_in;
   logic [LEN_W-1:0]  pend_idx_ff, pend_idx_in;
   logic [BYTE_W-1:0] last_rd_ff, last_rd_in;

   // readout
   logic [LEN_W-1:0]  emit_idx_ff, emit_idx_in;
   logic [BYTE_W-1:0] ctr_lo_ff, ctr_lo_in;
   logic [BYTE_W-1:0] ctr_hi_ff, ctr_hi_in;
   logic              a_vld_ff, a_vld_in;
   logic [IDX_W-1:0]  a_idx_ff, a_idx_in;
   logic              a_last_ff, a_last_in;
   logic              b_vld_ff, b_vld_in;
   logic [BYTE_W-1:0] b_byte_ff, b_byte_in;
   logic [IDX_W-1:0]  b_idx_ff, b_idx_in;
   logic [CTR_W-1:0]  b_ctr_ff, b_ctr_in;
   logic              b_last_ff, b_last_in;

   // step decode
   logic [BYTE_W-1:0] lo_c, hi_c;
   logic [LEN_W-1:0]  len_c, len_m1_c, held_inc_c, off_new_c, q_c;
   logic              pair_c, slide_c, hit_new_c, seen_new_c, full_c;
   logic              emit_c, relock_c;
   logic              req_acc, rsp_acc, csr_acc, a_move;
   logic              scan_hit_c, scan_done_c, scan_issue_c, emit_issue_c;

   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = b_vld_ff && !rsp_stall;
   assign csr_acc = csr_valid && csr_ready;
   assign a_move  = a_vld_ff && (!b_vld_ff || !rsp_stall);

   assign rsp_valid         = b_vld_ff;
   assign rsp_out_byte      = b_byte_ff;
   assign rsp_byte_index    = b_idx_ff;
   assign rsp_frame_counter = b_ctr_ff;
   assign rsp_last_of_frame = b_last_ff;

   // saturate frame_length into the supported range
   always_comb begin
      if (flen_ff < LEN_W'(MIN_FRAME)) begin
         len_c = LEN_W'(MIN_FRAME);
      end else if (flen_ff > LEN_W'(MAX_FRAME)) begin
         len_c = LEN_W'(MAX_FRAME);
      end else begin
         len_c = flen_ff;
      end
      len_m1_c = len_c - LEN_W'(1);
   end

   // decode what the incoming byte does to the frame
   always_comb begin
      lo_c       = sync_ff[BYTE_W-1:0];
      hi_c       = sync_ff[SYNC_W-1:BYTE_W];
      pair_c     = (prev_ff == lo_c) && (req_rx_byte == hi_c);
      slide_c    = held_ff >= len_c;
      held_inc_c = held_ff + LEN_W'(1);
      hit_new_c  = !seen_ff && (held_ff != '0) && pair_c;
      seen_new_c = seen_ff || hit_new_c;
      off_new_c  = hit_new_c ? (held_ff - LEN_W'(1)) : off_ff;
      full_c     = held_inc_c == len_c;
      q_c        = off_new_c + LEN_W'(SYNC_BYTES);
      emit_c     = 1'b0;
      relock_c   = 1'b0;
      if (slide_c) begin
         emit_c = pair_c;
      end else if (full_c) begin
         if (lock_ff && pair_c) begin
            emit_c = 1'b1;
         end else if (seen_new_c) begin
            if (q_c >= len_c) begin
               emit_c = 1'b1;
            end else begin
               relock_c = 1'b1;
            end
         end
      end
   end

   // relock scan: compare each read byte with the one read before it
   always_comb begin
      scan_hit_c   = pend_ff && (pend_idx_ff != '0) && (last_rd_ff == lo_c)
                     && (rd_data_ff == hi_c);
      scan_done_c  = scan_hit_c || (!pend_ff && (scan_idx_ff >= held_ff));
      scan_issue_c = (state_ff == ST_SCAN) && !a_vld_ff && !scan_hit_c
                     && (scan_idx_ff < held_ff);
      emit_issue_c = (state_ff == ST_EMIT) && (!a_vld_ff || a_move);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && emit_c) begin
               state_in = ST_CTR_LO;
            end else if (req_acc && relock_c) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done_c) begin
               state_in = ST_IDLE;
            end
         end
         ST_CTR_LO: begin
            if (!a_vld_ff) begin
               state_in = ST_CTR_HI;
            end
         end
         ST_CTR_HI:   state_in = ST_CTR_DONE;
         ST_CTR_DONE: state_in = ST_EMIT;
         ST_EMIT: begin
            if (emit_issue_c && (emit_idx_ff == len_m1_c)) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // handshake and store port control
   always_comb begin
      req_stall = (state_ff != ST_IDLE) || csr_valid;
      csr_ready = state_ff == ST_IDLE;
      wr_en     = req_acc;
      wr_addr   = slide_c ? AW'(base_ff + AW'(len_c)) : AW'(base_ff + AW'(held_ff));
      rd_en     = 1'b0;
      rd_addr   = base_ff;
      case (state_ff)
         ST_SCAN: begin
            rd_en   = scan_issue_c;
            rd_addr = AW'(base_ff + AW'(scan_idx_ff));
         end
         ST_CTR_LO: begin
            rd_en   = !a_vld_ff;
            rd_addr = base_ff;
         end
         ST_CTR_HI: begin
            rd_en   = 1'b1;
            rd_addr = AW'(base_ff + AW'(1));
         end
         ST_EMIT: begin
            rd_en   = emit_issue_c;
            rd_addr = AW'(base_ff + AW'(emit_idx_ff));
         end
         default: begin
            rd_en   = 1'b0;
            rd_addr = base_ff;
         end
      endcase
   end

   // frame tracking, scan and readout datapath
   always_comb begin
      sync_in     = sync_ff;
      flen_in     = flen_ff;
      lock_in     = lock_ff;
      held_in     = held_ff;
      prev_in     = prev_ff;
      off_in      = off_ff;
      seen_in     = seen_ff;
      base_in     = base_ff;
      scan_idx_in = scan_idx_ff;
      pend_in     = 1'b0;
      pend_idx_in = scan_idx_ff;
      last_rd_in  = pend_ff ? rd_data_ff : last_rd_ff;
      emit_idx_in = emit_idx_ff;
      ctr_lo_in   = ctr_lo_ff;
      ctr_hi_in   = ctr_hi_ff;

      if (csr_acc) begin
         if (csr_index == REG_SYNC_WORD) begin
            sync_in = csr_data[SYNC_W-1:0];
         end
         if (csr_index == REG_FRAME_LENGTH) begin
            flen_in = csr_data[LEN_W-1:0];
         end
         // restart the hunt on any known register
         if ((csr_index == REG_SYNC_WORD) || (csr_index == REG_FRAME_LENGTH)) begin
            lock_in = 1'b0;
            held_in = '0;
            prev_in = '0;
            off_in  = '0;
            seen_in = 1'b0;
         end
      end

      if (req_acc) begin
         prev_in     = req_rx_byte;
         scan_idx_in = '0;
         if (slide_c) begin
            // full window while hunting: slide it by one byte
            base_in = AW'(base_ff + AW'(1));
            held_in = len_c;
            lock_in = 1'b0;
            seen_in = 1'b0;
            off_in  = '0;
         end else begin
            held_in = held_inc_c;
            seen_in = seen_new_c;
            off_in  = off_new_c;
            if (relock_c) begin
               // keep the bytes after the first sync pair as the next frame
               base_in = AW'(base_ff + AW'(q_c));
               held_in = len_c - q_c;
               lock_in = 1'b1;
               seen_in = 1'b0;
               off_in  = '0;
            end else if (full_c) begin
               lock_in = 1'b0;
            end
         end
         if (emit_c) begin
            lock_in = 1'b1;
            held_in = '0;
            seen_in = 1'b0;
            off_in  = '0;
         end
      end

      if (state_ff == ST_SCAN) begin
         pend_in = scan_issue_c;
         if (scan_issue_c) begin
            scan_idx_in = scan_idx_ff + LEN_W'(1);
         end
         if (scan_hit_c) begin
            seen_in = 1'b1;
            off_in  = pend_idx_ff - LEN_W'(1);
         end
      end

      if (state_ff == ST_CTR_HI) begin
         ctr_lo_in = rd_data_ff;
      end
      if (state_ff == ST_CTR_DONE) begin
         ctr_hi_in   = rd_data_ff;
         emit_idx_in = '0;
      end
      if (emit_issue_c) begin
         emit_idx_in = emit_idx_ff + LEN_W'(1);
      end
   end

   // read stage and output register
   always_comb begin
      a_vld_in  = a_vld_ff;
      a_idx_in  = a_idx_ff;
      a_last_in = a_last_ff;
      if (a_move) begin
         a_vld_in = 1'b0;
      end
      if (emit_issue_c) begin
         a_vld_in  = 1'b1;
         a_idx_in  = IDX_W'(emit_idx_ff);
         a_last_in = emit_idx_ff == len_m1_c;
      end

      b_vld_in  = b_vld_ff;
      b_byte_in = b_byte_ff;
      b_idx_in  = b_idx_ff;
      b_ctr_in  = b_ctr_ff;
      b_last_in = b_last_ff;
      if (rsp_acc) begin
         b_vld_in = 1'b0;
      end
      if (a_move) begin
         b_vld_in  = 1'b1;
         b_byte_in = rd_data_ff;
         b_idx_in  = a_idx_ff;
         b_ctr_in  = {ctr_hi_ff, ctr_lo_ff};
         b_last_in = a_last_ff;
      end
   end

   // frame store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_store_ff[wr_addr] <= req_rx_byte;
      end
      if (rd_en) begin
         rd_data_ff <= frame_store_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         sync_ff     <= '0;
         flen_ff     <= LEN_W'(LEN_RESET);
         lock_ff     <= 1'b0;
         held_ff     <= '0;
         prev_ff     <= '0;
         off_ff      <= '0;
         seen_ff     <= 1'b0;
         base_ff     <= '0;
         scan_idx_ff <= '0;
         pend_ff     <= 1'b0;
         emit_idx_ff <= '0;
         a_vld_ff    <= 1'b0;
         b_vld_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         sync_ff     <= sync_in;
         flen_ff     <= flen_in;
         lock_ff     <= lock_in;
         held_ff     <= held_in;
         prev_ff     <= prev_in;
         off_ff      <= off_in;
         seen_ff     <= seen_in;
         base_ff     <= base_in;
         scan_idx_ff <= scan_idx_in;
         pend_ff     <= pend_in;
         emit_idx_ff <= emit_idx_in;
         a_vld_ff    <= a_vld_in;
         b_vld_ff    <= b_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff <= pend_idx_in;
      last_rd_ff  <= last_rd_in;
      ctr_lo_ff   <= ctr_lo_in;
      ctr_hi_ff   <= ctr_hi_in;
      a_idx_ff    <= a_idx_in;
      a_last_ff   <= a_last_in;
      b_byte_ff   <= b_byte_in;
      b_idx_ff    <= b_idx_in;
      b_ctr_ff    <= b_ctr_in;
      b_last_ff   <= b_last_in;
   end

endmodule

[rtl/core/tfs_checker.sv]
// Port-level checks for the telemetry frame synchronizer, bound to its top.
// Depends on tfs_pkg and telemetry_frame_synchronizer.
module tfs_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_stall,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [tfs_pkg::BYTE_W-1:0]  rsp_out_byte,
   input  logic [tfs_pkg::IDX_W-1:0]   rsp_byte_index,
   input  logic [tfs_pkg::CTR_W-1:0]   rsp_frame_counter,
   input  logic                        rsp_last_of_frame,
   input  logic                        csr_valid
);
   import tfs_pkg::*;

   logic [IDX_W-1:0] exp_idx_ff;
   logic [CTR_W-1:0] ctr_ff;
   logic             mid_ff;
   logic             rsp_acc;

   assign rsp_acc = rsp_valid && !rsp_stall;

   // track the expected position and counter within a frame
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_idx_ff <= '0;
         mid_ff     <= 1'b0;
      end else if (rsp_acc) begin
         exp_idx_ff <= rsp_last_of_frame ? '0 : (rsp_byte_index + IDX_W'(1));
         mid_ff     <= !rsp_last_of_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_acc) begin
         ctr_ff <= rsp_frame_counter;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_byte_index) && $stable(rsp_last_of_frame))
      else $error("stalled beat changed");

   a_idx_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_byte_index == exp_idx_ff)
      else $error("byte index out of sequence");

   a_ctr_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_byte_index == IDX_W'(0))
         |-> rsp_frame_counter[BYTE_W-1:0] == rsp_out_byte)
      else $error("frame counter low byte differs from first frame byte");

   a_ctr_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && mid_ff |-> rsp_frame_counter == ctr_ff)
      else $error("frame counter changed within a frame");

   a_csr_blocks_req: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> req_stall)
      else $error("input taken during a register write");

endmodule

bind telemetry_frame_synchronizer tfs_checker u_tfs_checker (.*);

[tb/telemetry_frame_synchronizer_tb.sv]
// Self-checking testbench for telemetry_frame_synchronizer: byte stimulus, frame prediction,
// per-beat result checks. Depends on tfs_pkg and the synchronizer RTL only.
module telemetry_frame_synchronizer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tfs_pkg::*;

   // index 3 maps to no register; a write there must change nothing
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = CSR_IDX_W'(3);

   // relock scan and frame readout both stay below this, with margin
   localparam int SETTLE_CYCLES = 2 * MAX_FRAME_DEF + 8;
   // longest stretch with no beat on any channel before the run is abandoned
   localparam int QUIET_LIMIT   = 3000;
   localparam int LONG_HOLD     = 400;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic [IDX_W-1:0]  index;
      logic [CTR_W-1:0]  counter;
      logic              is_last;
   } frame_byte_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [BYTE_W-1:0]     req_rx_byte = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [BYTE_W-1:0]     rsp_out_byte;
   logic [IDX_W-1:0]      rsp_byte_index;
   logic [CTR_W-1:0]      rsp_frame_counter;
   logic                  rsp_last_of_frame;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   telemetry_frame_synchronizer i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_byte_index    (rsp_byte_index),
      .rsp_frame_counter (rsp_frame_counter),
      .rsp_last_of_frame (rsp_last_of_frame),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      #2;
      clock = 1'b1;
      #2;
      clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Frame predictor: its own copy of the registers and framing state.
   // ------------------------------------------------------------------
   logic [SYNC_W-1:0] sync_pattern;
   logic [LEN_W-1:0]  len_reg;
   logic [BYTE_W-1:0] held_bytes [MAX_FRAME_DEF];
   logic              locked;
   int                held_count;
   logic [BYTE_W-1:0] last_rx;
   int                pair_pos;
   logic              pair_found;

   // frame bytes still owed by the block, oldest first
   frame_byte_type frame_bytes_due[$];

   int  mismatches   = 0;
   int  bytes_sent   = 0;
   bit  idling_on    = 1'b1;
   int  long_hold    = 0;
   int  stall_left   = 0;
   int  quiet_cycles = 0;

   // Clamp the length register into the legal frame range.
   function automatic int frame_len();
      int n;
      n = int'(len_reg);
      if (n < MIN_FRAME)
         n = MIN_FRAME;
      if (n > MAX_FRAME_DEF)
         n = MAX_FRAME_DEF;
      return n;
   endfunction

   function automatic void restart_hunt();
      locked     = 1'b0;
      held_count = 0;
      last_rx    = '0;
      pair_pos   = 0;
      pair_found = 1'b0;
   endfunction

   // Queue every byte of the held frame and lock onto the stream.
   function automatic void emit_frame(input int len);
      frame_byte_type fb;
      logic [CTR_W-1:0] ctr;
      int k;
      ctr = {held_bytes[1], held_bytes[0]};
      for (k = 0; k < len; k++) begin
         fb.data    = held_bytes[k];
         fb.index   = IDX_W'(k);
         fb.counter = ctr;
         fb.is_last = (k == len - 1);
         frame_bytes_due.push_back(fb);
      end
      locked     = 1'b1;
      held_count = 0;
      pair_found = 1'b0;
      pair_pos   = 0;
   endfunction

   // Find the first sync pair that lies wholly among the kept bytes.
   function automatic void find_first_pair();
      int i;
      pair_found = 1'b0;
      pair_pos   = 0;
      for (i = 0; i + 1 < held_count; i++) begin
         if (held_bytes[i] == sync_pattern[7:0] && held_bytes[i+1] == sync_pattern[15:8]) begin
            pair_found = 1'b1;
            pair_pos   = i;
            break;
         end
      end
   endfunction

   // Advance the framing state by one received byte.
   function automatic void absorb_byte(input logic [BYTE_W-1:0] b);
      int len, n, q, k;
      logic lo_hit;
      len    = frame_len();
      n      = held_count;
      lo_hit = (last_rx == sync_pattern[7:0]) && (b == sync_pattern[15:8]);
      if (n >= len) begin
         // hunting with a full window: slide it by one byte
         for (k = 0; k < len - 1; k++)
            held_bytes[k] = held_bytes[k+1];
         held_bytes[len-1] = b;
         last_rx    = b;
         held_count = len;
         locked     = 1'b0;
         if (lo_hit)
            emit_frame(len);
         else begin
            pair_found = 1'b0;
            pair_pos   = 0;
         end
      end else begin
         if (n >= 1 && !pair_found && lo_hit) begin
            pair_found = 1'b1;
            pair_pos   = n - 1;
         end
         held_bytes[n] = b;
         last_rx       = b;
         n++;
         held_count    = n;
         if (n == len) begin
            if (locked && held_bytes[len-2] == sync_pattern[7:0]
                && held_bytes[len-1] == sync_pattern[15:8])
               emit_frame(len);
            else begin
               locked = 1'b0;
               if (pair_found) begin
                  q = pair_pos + 2;
                  if (q >= len)
                     emit_frame(len);
                  else begin
                     // relock just after the first pair, keep what follows it
                     for (k = 0; k < len - q; k++)
                        held_bytes[k] = held_bytes[k+q];
                     held_count = len - q;
                     locked     = 1'b1;
                     find_first_pair();
                  end
               end
            end
         end
      end
   endfunction

   // ------------------------------------------------------------------
   // Result side: drive rsp_stall at the falling edge, in random bursts
   // while idling is on, or for one long hold requested by a test.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else if (long_hold > 0) begin
         rsp_stall <= 1'b1;
         long_hold--;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left = $urandom_range(0, 16);
      end else
         rsp_stall <= 1'b0;
   end

   // Check each accepted result beat against the oldest owed frame byte,
   // and abandon the run if no channel moves a beat for too long.
   always @(posedge clock) begin
      frame_byte_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (frame_bytes_due.size() == 0) begin
               $error("unexpected frame beat: out_byte %0h byte_index %0d",
                      rsp_out_byte, rsp_byte_index);
               mismatches++;
            end else begin
               want = frame_bytes_due.pop_front();
               if (rsp_out_byte !== want.data) begin
                  $error("out_byte expected %0h actual %0h", want.data, rsp_out_byte);
                  mismatches++;
               end
               if (rsp_byte_index !== want.index) begin
                  $error("byte_index expected %0d actual %0d", want.index, rsp_byte_index);
                  mismatches++;
               end
               if (rsp_frame_counter !== want.counter) begin
                  $error("frame_counter expected %0h actual %0h",
                         want.counter, rsp_frame_counter);
                  mismatches++;
               end
               if (rsp_last_of_frame !== want.is_last) begin
                  $error("last_of_frame expected %0b actual %0b",
                         want.is_last, rsp_last_of_frame);
                  mismatches++;
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Shared drivers
   // ------------------------------------------------------------------

   // Offer one byte; hold it until the block takes the beat.
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      int gap;
      @(negedge clock);
      if (idling_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 17);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do
         @(posedge clock);
      while (req_stall);
      absorb_byte(b);
      bytes_sent++;
   endtask

   task automatic wait_drained();
      while (frame_bytes_due.size() != 0)
         @(posedge clock);
   endtask

   // Drop valid, collect every owed byte, then let any relock scan finish.
   task automatic let_block_settle();
      @(negedge clock);
      req_valid <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      let_block_settle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      if (idx == REG_SYNC_WORD) begin
         sync_pattern = value;
         restart_hunt();
      end else if (idx == REG_FRAME_LENGTH) begin
         len_reg = value[LEN_W-1:0];
         restart_hunt();
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly the sync bytes, so that pairs form inside noise.
   function automatic logic [BYTE_W-1:0] pick_noise_byte();
      case ($urandom_range(0, 2))
         0: return sync_pattern[7:0];
         1: return sync_pattern[15:8];
         default: return BYTE_W'($urandom);
      endcase
   endfunction

   // Send one frame with random counter and payload, ending in the sync word.
   // Optionally plant a sync pair early in the frame, or damage the sync word.
   task automatic send_frame(input bit plant_pair, input bit damage_sync);
      logic [BYTE_W-1:0] fb [MAX_FRAME_DEF];
      int len, pos, k;
      len = frame_len();
      for (k = 0; k < len; k++)
         fb[k] = BYTE_W'($urandom);
      fb[len-2] = sync_pattern[7:0];
      fb[len-1] = sync_pattern[15:8];
      if (plant_pair) begin
         pos         = $urandom_range(0, len - 4);
         fb[pos]     = sync_pattern[7:0];
         fb[pos + 1] = sync_pattern[15:8];
      end
      if (damage_sync) begin
         pos     = len - 2 + $urandom_range(0, 1);
         fb[pos] = fb[pos] ^ BYTE_W'(1 << $urandom_range(0, 7));
      end
      for (k = 0; k < len; k++)
         send_byte(fb[k]);
   endtask

   // Mostly clean frames, some damaged ones and bursts of noise; now and
   // then pause the sender until every owed byte has come out.
   task automatic send_traffic(input int count);
      int start, pick, k, run;
      start = bytes_sent;
      while (bytes_sent - start < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 70)
            send_frame(pick < 12, 1'b0);
         else if (pick < 85)
            send_frame(1'($urandom_range(0, 1)), 1'b1);
         else begin
            run = $urandom_range(1, frame_len());
            for (k = 0; k < run; k++)
               send_byte(pick_noise_byte());
         end
         if ($urandom_range(0, 15) == 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            wait_drained();
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Bytes at the reset setting, restarts on each register write, a spare
   // index that must leave pair tracking alone, and lengths below the minimum.
   task automatic test_register_writes();
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h00);
      write_reg(REG_SYNC_WORD, 16'hA55A);
      write_reg(REG_FRAME_LENGTH, 16'hFF80);
      send_byte(8'h5A);
      write_reg(REG_SPARE, 16'hFFFF);
      send_byte(8'hA5);
      send_byte(8'h11);
      send_byte(8'h22);
      send_byte(8'h5A);
      send_byte(8'hA5);
      write_reg(REG_FRAME_LENGTH, 16'h0003);
      send_byte(8'hFF);
      send_byte(8'h00);
   endtask

   // Four-byte frames: early pair while hunting, locked frames, mismatch
   // without a pair, pair at the end of a sliding window, relock after a
   // failed frame.
   task automatic test_framing_cases();
      logic [BYTE_W-1:0] seq [] = '{
         8'h5A, 8'hA5, 8'h00, 8'hFF, 8'h5A, 8'hA5,
         8'hFF, 8'h00, 8'h5A, 8'hA5,
         8'h12, 8'h34, 8'h56, 8'h78,
         8'h9A, 8'h5A, 8'hA5,
         8'h00, 8'h5A, 8'hA5, 8'h5A,
         8'hA5, 8'h01, 8'h5A, 8'hA5 };
      int k;
      write_reg(REG_FRAME_LENGTH, 16'h0002);
      write_reg(REG_SYNC_WORD, 16'hA55A);
      for (k = 0; k < seq.size(); k++)
         send_byte(seq[k]);
   endtask

   // Hold the result side for a long stretch while frames keep coming so
   // the block fills and stalls its input; then drain before going on.
   task automatic test_backpressure();
      int start;
      write_reg(REG_FRAME_LENGTH, 16'd4);
      write_reg(REG_SYNC_WORD, SYNC_W'($urandom));
      @(posedge clock);
      long_hold = LONG_HOLD;
      start = bytes_sent;
      while (bytes_sent - start < 40)
         send_frame(1'b0, 1'b0);
      @(negedge clock);
      req_valid <= 1'b0;
      wait_drained();
      send_traffic(12);
   endtask

   // Random traffic over several register settings, including sync words
   // whose two bytes are equal, where pairs can straddle a relock point.
   task automatic test_random_traffic();
      logic [BYTE_W-1:0] twin;
      write_reg(REG_SYNC_WORD, SYNC_W'($urandom));
      write_reg(REG_FRAME_LENGTH, CSR_DATA_W'($urandom_range(4, 12)));
      send_traffic(40);
      write_reg(REG_SYNC_WORD, 16'h0000);
      write_reg(REG_FRAME_LENGTH, 16'h0000);
      send_traffic(20);
      twin = BYTE_W'($urandom);
      write_reg(REG_SYNC_WORD, {twin, twin});
      write_reg(REG_FRAME_LENGTH, 16'd7);
      send_traffic(20);
   endtask

   // Largest frames: a length above the maximum saturates to it.
   task automatic test_long_frames();
      write_reg(REG_SYNC_WORD, 16'hFFFF);
      write_reg(REG_FRAME_LENGTH, 16'h007F);
      send_traffic(30);
      write_reg(REG_FRAME_LENGTH, 16'd65);
      write_reg(REG_SYNC_WORD, SYNC_W'($urandom));
      send_traffic(10);
   endtask

   // Back-to-back beats on both sides, no idling.
   task automatic test_steady_stream();
      write_reg(REG_SYNC_WORD, SYNC_W'($urandom));
      write_reg(REG_FRAME_LENGTH, 16'hFF84);
      @(posedge clock);
      idling_on = 1'b0;
      send_traffic(20);
      write_reg(REG_FRAME_LENGTH, 16'd64);
      send_traffic(10);
   endtask

   initial begin
      sync_pattern = '0;
      len_reg      = LEN_W'(LEN_RESET);
      restart_hunt();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_register_writes();
      test_framing_cases();
      test_backpressure();
      test_random_traffic();
      test_long_frames();
      test_steady_stream();

      // collect the tail, then give the block time to show stray beats
      let_block_settle();
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
